>>> sv/ri_pkg.sv
package ri_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned RANK_W       = 6;
  localparam int unsigned MAX_ELEMENTS = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // write the incoming value into the selected cell
    logic compare;  // broadcast one stored value; cells with a larger key count it
    logic advance;  // shift ranks toward the output after a transaction
  } ri_cmd_t;

endpackage

>>> sv/ri_ctrl.sv
module ri_ctrl #(
  parameter int unsigned MAX_ELEMENTS = ri_pkg::MAX_ELEMENTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_is_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_last_rank,
  output logic                                  out_overflow,
  output ri_pkg::ri_cmd_t                       cmd,
  output logic [$clog2(MAX_ELEMENTS)-1:0]       load_idx
);
  import ri_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RANK,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic               ovf_r, ovf_nxt;
  logic               room;
  logic               at_end;

  assign room     = (cnt_r < CNT_W'(MAX_ELEMENTS));
  assign at_end   = (step_r == cnt_r - CNT_W'(1));
  assign load_idx = cnt_r[IDX_W-1:0];

  // Handshake and datapath commands follow the state
  always_comb begin
    in_ready      = (state_r == ST_LOAD);
    out_valid     = (state_r == ST_EMIT);
    out_last_rank = (state_r == ST_EMIT) && at_end;
    out_overflow  = ovf_r;
    cmd.load      = (state_r == ST_LOAD) && in_valid && room;
    cmd.compare   = (state_r == ST_RANK);
    cmd.advance   = (state_r == ST_EMIT) && out_ready;
  end

  // Next state: load values, run one compare pass per stored value, then emit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (room) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            state_nxt = ST_RANK;
            step_nxt  = '0;
          end
        end
      end
      ST_RANK: begin
        if (at_end) begin
          state_nxt = ST_EMIT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (at_end) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      step_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> sv/ri_datapath.sv
module ri_datapath #(
  parameter int unsigned MAX_ELEMENTS = ri_pkg::MAX_ELEMENTS
) (
  input  logic                                  clk,
  input  ri_pkg::ri_cmd_t                       cmd,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]       load_idx,
  input  logic signed [ri_pkg::VALUE_W-1:0]     in_value,
  output logic [ri_pkg::RANK_W-1:0]             out_rank
);
  import ri_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);

  // Each cell keeps its own value and rank; a second row shifts copies toward cell 0
  logic signed [VALUE_W-1:0] key_r [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] rot_r [MAX_ELEMENTS];
  logic [RANK_W-1:0]         rank_r [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] probe;

  assign probe    = rot_r[0];
  assign out_rank = rank_r[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      // Store the incoming value into the addressed cell
      if (cmd.load && (load_idx == IDX_W'(i))) begin
        key_r[i]  <= in_value;
        rot_r[i]  <= in_value;
        rank_r[i] <= '0;
      end else if (cmd.compare) begin
        // Shift the probe row down and count probes strictly below this key
        if (i < MAX_ELEMENTS - 1) begin
          rot_r[i] <= rot_r[i+1];
        end
        if (probe < key_r[i]) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end else if (cmd.advance) begin
        // Move ranks toward the output after each transaction
        if (i < MAX_ELEMENTS - 1) begin
          rank_r[i] <= rank_r[i+1];
        end
      end
    end
  end

endmodule

>>> sv/rank_indexer_core.sv
// Ranks a sequence of signed 32-bit values: each input transaction loads one
// value into a row of MAX_ELEMENTS cells, and the transaction flagged is_last
// starts ranking. Each result gives how many loaded values are strictly smaller
// than that element, in input order, so equal values share a rank; last_rank
// marks the final result and overflow reports values dropped for lack of room.
// Timing: values load while in_ready is high; after the last value the block
// broadcasts each stored value in turn to all cells (one signed compare per
// cell per cycle), then offers the results in input order at one per cycle
// while out_ready is high. Input is not accepted while ranking or emitting.
module rank_indexer_core #(
  parameter int unsigned MAX_ELEMENTS = ri_pkg::MAX_ELEMENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ri_pkg::VALUE_W-1:0] in_value,
  input  logic                              in_is_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ri_pkg::RANK_W-1:0]         out_rank,
  output logic                              out_last_rank,
  output logic                              out_overflow
);
  import ri_pkg::*;

  ri_cmd_t                         cmd;
  logic [$clog2(MAX_ELEMENTS)-1:0] load_idx;

  ri_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow),
    .cmd           (cmd),
    .load_idx      (load_idx)
  );

  ri_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .load_idx (load_idx),
    .in_value (in_value),
    .out_rank (out_rank)
  );

endmodule

>>> sv/ri_checker.sv
module ri_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_is_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ri_pkg::RANK_W-1:0]         out_rank,
  input logic                              out_last_rank,
  input logic                              out_overflow
);

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // A closing input transaction blocks further input while ranking
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_is_last) |=> !in_ready)
    else $error("input accepted during ranking");

  // The final result ends the burst
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_rank) |=> (!out_valid && in_ready))
    else $error("results continue after final rank");

  // Overflow is one value for the whole burst
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |-> $stable(out_overflow))
    else $error("overflow changed within a burst");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_rank) && $stable(out_last_rank)))
    else $error("stalled result changed");

endmodule

bind rank_indexer_core ri_checker u_ri_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import ri_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 3 * MAX_ELEMENTS + 16;
  localparam int RANDOM_ITEMS = 60;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
    logic              overflow;
  } rank_result_t;

  // Value generation modes for random sequences
  typedef enum int {
    VAL_FULL,
    VAL_NARROW,
    VAL_EDGES
  } value_mode_e;

  // Receiver stall modes
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE
  } ready_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  value_t                in_value = '0;
  logic                  in_is_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RANK_W-1:0]     out_rank;
  logic                  out_last_rank;
  logic                  out_overflow;

  // Predictor state: the values of the sequence being loaded
  value_t                loaded_vals [MAX_ELEMENTS];
  int                    loaded_count = 0;
  logic                  dropped_seen = 1'b0;
  rank_result_t          ranks_due [$];

  // Stimulus scratch and bookkeeping
  value_t                seq_buf [$];
  int                    burst_left = 0;
  int                    error_count = 0;
  int                    cycle_count = 0;
  int                    items_taken = 0;
  int                    ranks_checked = 0;
  int                    sequences_sent = 0;
  int                    overflow_sequences = 0;

  rank_indexer_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rank      (out_rank),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ranks still due", cycle_count, ranks_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Rank every loaded value against all loaded values and queue the results
  task automatic compute_ranks();
    int r;
    for (int i = 0; i < loaded_count; i++) begin
      r = 0;
      for (int j = 0; j < loaded_count; j++) begin
        if (loaded_vals[j] < loaded_vals[i]) r++;
      end
      ranks_due.push_back('{rank: r[RANK_W-1:0],
                            last_rank: (i == loaded_count - 1),
                            overflow: dropped_seen});
    end
  endtask

  // Check each result transaction, then fold each accepted input into the predictor
  always @(posedge clk) begin
    rank_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (ranks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result rank=%0d last=%0b ovf=%0b",
                                  out_rank, out_last_rank, out_overflow));
      end else begin
        exp_r = ranks_due.pop_front();
        ranks_checked++;
        if (out_rank !== exp_r.rank)
          report_mismatch($sformatf("rank got %0d want %0d", out_rank, exp_r.rank));
        if (out_last_rank !== exp_r.last_rank)
          report_mismatch($sformatf("last_rank got %0b want %0b",
                                    out_last_rank, exp_r.last_rank));
        if (out_overflow !== exp_r.overflow)
          report_mismatch($sformatf("overflow got %0b want %0b",
                                    out_overflow, exp_r.overflow));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      items_taken++;
      if (loaded_count < MAX_ELEMENTS) begin
        loaded_vals[loaded_count] = in_value;
        loaded_count++;
      end else begin
        dropped_seen = 1'b1;
      end
      if (in_is_last) begin
        if (dropped_seen) overflow_sequences++;
        compute_ranks();
        loaded_count = 0;
        dropped_seen = 1'b0;
      end
    end
  end

  // Receiver stalls: stretches of always-ready, coin-flip and mostly-stalled
  always @(negedge clk) begin
    ready_mode_e mode;
    int          left;
    if (left <= 0) begin
      mode = ready_mode_e'($urandom_range(0, 2));
      left = $urandom_range(8, 64);
    end
    left--;
    case (mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Send one item; open a new burst with a random gap when the last one ran out
  task automatic send_item(input value_t val, input logic last);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_value   <= val;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send seq_buf as one sequence, flagging the final entry
  task automatic send_seq();
    for (int i = 0; i < seq_buf.size(); i++) begin
      send_item(seq_buf[i], i == seq_buf.size() - 1);
    end
    sequences_sent++;
    seq_buf.delete();
  endtask

  function automatic value_t pick_value(input value_mode_e mode);
    value_t v;
    case (mode)
      VAL_FULL:   v = $urandom;
      VAL_NARROW: v = $signed($urandom_range(0, 7)) - 4;
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = 32'sh8000_0002;
          3:       v = 32'sh7FFF_FF9A;
          4:       v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  // Single-item sequences: rank is always zero and the one result is the last
  task automatic test_single_values();
    value_t picks [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
    foreach (picks[i]) begin
      seq_buf.push_back(picks[i]);
      send_seq();
    end
  endtask

  // Sign boundary and wrap-around values in one sequence
  task automatic test_extremes();
    seq_buf = {32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
               32'sh8000_0002, 32'sh7FFF_FF9A, 32'sh8000_0001};
    send_seq();
  endtask

  // Equal values share a rank
  task automatic test_duplicates();
    seq_buf = {5, 5, -3, 5, -3, 7};
    send_seq();
  endtask

  // Strictly descending input reverses the ranks
  task automatic test_descending();
    seq_buf = {40, 30, 20, 10, -10};
    send_seq();
  endtask

  // Overrun the store by two: it fills exactly, then a plain item and the
  // flagged item are both dropped
  task automatic test_store_full();
    for (int i = 0; i < MAX_ELEMENTS + 2; i++) begin
      seq_buf.push_back(pick_value(value_mode_e'($urandom_range(0, 2))));
    end
    send_seq();
  endtask

  // Random sequences, mostly short, a few long or past capacity
  task automatic test_random_sequences();
    int          start_items;
    int          len;
    int          sel;
    value_mode_e mode;
    start_items = items_taken;
    while (items_taken - start_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75)      len = $urandom_range(1, 8);
      else if (sel < 93) len = $urandom_range(9, 24);
      else if (sel < 97) len = MAX_ELEMENTS;
      else               len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
      mode = value_mode_e'($urandom_range(0, 2));
      for (int i = 0; i < len; i++) seq_buf.push_back(pick_value(mode));
      send_seq();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_values();
    test_extremes();
    test_duplicates();
    test_descending();
    test_store_full();
    test_random_sequences();

    // Release the input channel and drain the remaining ranks
    @(negedge clk);
    in_valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d sequences, %0d input items, %0d ranks checked",
             sequences_sent, items_taken, ranks_checked);
    $display("%0d sequences overran the store, %0d mismatches",
             overflow_sequences, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
